// ===== hw/rtl/depth_pixel_backprojection_macros.svh =====
// assertion macros for the depth pixel backprojection block
// expects signals named clk and rst_n in the scope of each use
`ifndef DEPTH_PIXEL_BACKPROJECTION_MACROS_SVH
`define DEPTH_PIXEL_BACKPROJECTION_MACROS_SVH

// same-cycle implication, checked out of reset
`define DPB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define DPB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/dpb_pkg.sv =====
// shared constants, register indexes and types for the depth pixel backprojection block
// no dependencies
`timescale 1ns / 1ps

package dpb_pkg;

    // coordinate bits used from row and column
    localparam int COORD_BITS = 12;

    // field widths
    localparam int PixelW   = 12;
    localparam int DepthW   = 16;
    localparam int ColorW   = 8;
    localparam int CenterW  = 16;
    localparam int InvW     = 24;
    localparam int ZW       = 32;
    localparam int CoordW   = 45;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 24;
    localparam int FracW    = 4;

    // derived arithmetic widths
    localparam int MagW      = CenterW;
    localparam int ProdW     = MagW + ZW;
    localparam int ProdShift = 28;
    localparam int TailShift = ProdShift - InvW;
    localparam int ScaledW   = ProdW - TailShift;
    localparam int ZShift    = 8;
    localparam int RgbW      = 3 * ColorW;
    localparam int InDataW   = 64;
    localparam int OutDataW  = 152;

    localparam logic [PixelW-1:0] CoordMask = PixelW'((64'd1 << COORD_BITS) - 64'd1);

    // register indexes
    localparam logic [CfgIdxW-1:0] RegCenterX      = 3'd0;
    localparam logic [CfgIdxW-1:0] RegCenterY      = 3'd1;
    localparam logic [CfgIdxW-1:0] RegInvFocalX    = 3'd2;
    localparam logic [CfgIdxW-1:0] RegInvFocalY    = 3'd3;
    localparam logic [CfgIdxW-1:0] RegInvDepthScale = 3'd4;

    // register reset values
    localparam logic [CenterW-1:0] CenterXRst       = 16'd5120;
    localparam logic [CenterW-1:0] CenterYRst       = 16'd3840;
    localparam logic [InvW-1:0]    InvFocalXRst     = 24'd32388;
    localparam logic [InvW-1:0]    InvFocalYRst     = 24'd32326;
    localparam logic [InvW-1:0]    InvDepthScaleRst = 24'd16777;

    // load enables of the projection stages
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } dpb_stage_en_t;

endpackage

// ===== hw/rtl/dpb_project.sv =====
// one axis of the projection: |offset| * z * inv_focal >> 28 with the sign put back
// depends on dpb_pkg; stage enables come from the top level pipeline control
`timescale 1ns / 1ps

module dpb_project
(
    input  logic                              clk,
    input  dpb_pkg::dpb_stage_en_t            en,
    input  logic [dpb_pkg::MagW-1:0]          mag,
    input  logic                              neg,
    input  logic [dpb_pkg::ZW-1:0]            z,
    input  logic [dpb_pkg::InvW-1:0]          inv_focal,
    output logic [dpb_pkg::CoordW-1:0]        coord
);

    logic [dpb_pkg::ProdW-1:0]   prod_reg;
    logic                        neg2_reg;
    logic [dpb_pkg::ProdW-1:0]   hi_reg;
    logic [dpb_pkg::ProdW-1:0]   lo_reg;
    logic                        neg3_reg;
    logic [dpb_pkg::ScaledW-1:0] scaled_reg;
    logic                        neg4_reg;
    logic [dpb_pkg::CoordW-1:0]  coord_reg;
    logic [dpb_pkg::ProdW-1:0]   sum_next;
    logic [dpb_pkg::CoordW-1:0]  pos_ext;

    // stage 2: offset magnitude times depth
    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            prod_reg <= dpb_pkg::ProdW'(mag) * dpb_pkg::ProdW'(z);
            neg2_reg <= neg;
        end
    end

    // stage 3: two partial products against the reciprocal
    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            hi_reg   <= dpb_pkg::ProdW'(prod_reg[dpb_pkg::ProdW-1:dpb_pkg::InvW])
                        * dpb_pkg::ProdW'(inv_focal);
            lo_reg   <= dpb_pkg::ProdW'(prod_reg[dpb_pkg::InvW-1:0])
                        * dpb_pkg::ProdW'(inv_focal);
            neg3_reg <= neg2_reg;
        end
    end

    // stage 4: combine partials, exact floor of the full product over 2^28
    assign sum_next = hi_reg + dpb_pkg::ProdW'(lo_reg[dpb_pkg::ProdW-1:dpb_pkg::InvW]);

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            scaled_reg <= sum_next[dpb_pkg::ProdW-1:dpb_pkg::TailShift];
            neg4_reg   <= neg3_reg;
        end
    end

    // stage 5: apply the sign, wrap to the output width
    assign pos_ext = dpb_pkg::CoordW'(scaled_reg);

    always_ff @(posedge clk)
    begin
        if (en.s5)
        begin
            coord_reg <= neg4_reg ? (dpb_pkg::CoordW'(0) - pos_ext) : pos_ext;
        end
    end

    assign coord = coord_reg;

endmodule

// ===== hw/rtl/depth_pixel_backprojection.sv =====
// Depth pixel backprojection: turns one RGB-D pixel into a 3-D point with the pinhole model.
// A pixel transfer is taken every clock while the output side keeps up; each pixel passes
// in order through the depth scale, offset-times-depth, split reciprocal multiply, partial
// sum and sign stages. Pixels with zero depth are consumed and give no output transfer.
// The user must write registers through cfg_wr_en only while the block is idle; the block
// does not enforce this. Depends on dpb_pkg, dpb_project and the assertion macro header.
`timescale 1ns / 1ps
`include "depth_pixel_backprojection_macros.svh"

module depth_pixel_backprojection
(
    input  logic                              clk,
    input  logic                              rst_n,
    // pixel stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // pixel_row, pixel_column, depth_raw, blue_in, green_in, red_in
    input  logic [dpb_pkg::InDataW-1:0]       s_tdata,
    // point stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // point_x, point_y, point_z, blue_out, green_out, red_out, zero fill
    output logic [dpb_pkg::OutDataW-1:0]      m_tdata,
    // register writes
    input  logic                              cfg_wr_en,
    input  logic [dpb_pkg::CfgIdxW-1:0]       cfg_index,
    input  logic [dpb_pkg::CfgDataW-1:0]      cfg_wdata
);

    localparam int Stages = 5;
    localparam int PadW   = dpb_pkg::OutDataW - 2 * dpb_pkg::CoordW - dpb_pkg::ZW
                            - dpb_pkg::RgbW;

    logic [dpb_pkg::CenterW-1:0] center_x_reg;
    logic [dpb_pkg::CenterW-1:0] center_y_reg;
    logic [dpb_pkg::InvW-1:0]    inv_focal_x_reg;
    logic [dpb_pkg::InvW-1:0]    inv_focal_y_reg;
    logic [dpb_pkg::InvW-1:0]    inv_depth_scale_reg;

    logic [dpb_pkg::PixelW-1:0]  pixel_row;
    logic [dpb_pkg::PixelW-1:0]  pixel_column;
    logic [dpb_pkg::DepthW-1:0]  depth_raw;
    logic [dpb_pkg::RgbW-1:0]    rgb_in;

    logic [Stages-1:0]           valid_reg;
    logic [Stages-1:0]           valid_next;
    logic [Stages-1:0]           adv;
    logic                        in_xfer;

    logic [dpb_pkg::MagW-1:0]    mag_x_next;
    logic [dpb_pkg::MagW-1:0]    mag_y_next;
    logic                        neg_x_next;
    logic                        neg_y_next;
    logic [dpb_pkg::ZW-1:0]      z_next;
    logic [dpb_pkg::MagW-1:0]    pos_x;
    logic [dpb_pkg::MagW-1:0]    pos_y;

    logic [dpb_pkg::MagW-1:0]    mag_x_reg;
    logic [dpb_pkg::MagW-1:0]    mag_y_reg;
    logic                        neg_x_reg;
    logic                        neg_y_reg;
    logic [dpb_pkg::ZW-1:0]      z_reg   [Stages];
    logic [dpb_pkg::RgbW-1:0]    rgb_reg [Stages];

    dpb_pkg::dpb_stage_en_t      stage_en;
    logic [dpb_pkg::CoordW-1:0]  point_x;
    logic [dpb_pkg::CoordW-1:0]  point_y;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg        <= dpb_pkg::CenterXRst;
            center_y_reg        <= dpb_pkg::CenterYRst;
            inv_focal_x_reg     <= dpb_pkg::InvFocalXRst;
            inv_focal_y_reg     <= dpb_pkg::InvFocalYRst;
            inv_depth_scale_reg <= dpb_pkg::InvDepthScaleRst;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                dpb_pkg::RegCenterX:       center_x_reg        <= cfg_wdata[dpb_pkg::CenterW-1:0];
                dpb_pkg::RegCenterY:       center_y_reg        <= cfg_wdata[dpb_pkg::CenterW-1:0];
                dpb_pkg::RegInvFocalX:     inv_focal_x_reg     <= cfg_wdata[dpb_pkg::InvW-1:0];
                dpb_pkg::RegInvFocalY:     inv_focal_y_reg     <= cfg_wdata[dpb_pkg::InvW-1:0];
                dpb_pkg::RegInvDepthScale: inv_depth_scale_reg <= cfg_wdata[dpb_pkg::InvW-1:0];
                default:                   ;
            endcase
        end
    end

    // unpack the pixel
    assign pixel_row    = s_tdata[11:0] & dpb_pkg::CoordMask;
    assign pixel_column = s_tdata[23:12] & dpb_pkg::CoordMask;
    assign depth_raw    = s_tdata[39:24];
    assign rgb_in       = s_tdata[63:40];

    // pipeline advance, a stage moves when empty or when its successor moves
    always_comb
    begin
        adv[Stages-1] = !valid_reg[Stages-1] || m_tready;
        for (int i = Stages - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign s_tready = adv[0];
    assign in_xfer  = s_tvalid && s_tready;

    // valid bits, zero depth drops the pixel at entry
    always_comb
    begin
        valid_next = valid_reg;
        if (adv[0])
        begin
            valid_next[0] = in_xfer && (depth_raw != '0);
        end
        for (int i = 1; i < Stages; i++)
        begin
            if (adv[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // stage 1: depth scale and signed pixel offsets in Q.4
    assign pos_x  = {pixel_column, dpb_pkg::FracW'(0)};
    assign pos_y  = {pixel_row, dpb_pkg::FracW'(0)};

    always_comb
    begin
        z_next     = dpb_pkg::ZW'((dpb_pkg::ZW + dpb_pkg::ZShift)'(depth_raw)
                     * (dpb_pkg::ZW + dpb_pkg::ZShift)'(inv_depth_scale_reg) >> dpb_pkg::ZShift);
        neg_x_next = pos_x < center_x_reg;
        neg_y_next = pos_y < center_y_reg;
        mag_x_next = neg_x_next ? (center_x_reg - pos_x) : (pos_x - center_x_reg);
        mag_y_next = neg_y_next ? (center_y_reg - pos_y) : (pos_y - center_y_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            mag_x_reg  <= mag_x_next;
            mag_y_reg  <= mag_y_next;
            neg_x_reg  <= neg_x_next;
            neg_y_reg  <= neg_y_next;
        end
    end

    // depth and color ride along with the projection stages
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            z_reg[0]   <= z_next;
            rgb_reg[0] <= rgb_in;
        end
        for (int i = 1; i < Stages; i++)
        begin
            if (adv[i])
            begin
                z_reg[i]   <= z_reg[i-1];
                rgb_reg[i] <= rgb_reg[i-1];
            end
        end
    end

    assign stage_en.s2 = adv[1];
    assign stage_en.s3 = adv[2];
    assign stage_en.s4 = adv[3];
    assign stage_en.s5 = adv[4];

    // horizontal axis
    dpb_project u_proj_x
    (
        .clk       (clk),
        .en        (stage_en),
        .mag       (mag_x_reg),
        .neg       (neg_x_reg),
        .z         (z_reg[0]),
        .inv_focal (inv_focal_x_reg),
        .coord     (point_x)
    );

    // vertical axis
    dpb_project u_proj_y
    (
        .clk       (clk),
        .en        (stage_en),
        .mag       (mag_y_reg),
        .neg       (neg_y_reg),
        .z         (z_reg[0]),
        .inv_focal (inv_focal_y_reg),
        .coord     (point_y)
    );

    // output transfer
    assign m_tvalid = valid_reg[Stages-1];
    assign m_tdata  = {PadW'(0), rgb_reg[Stages-1], z_reg[Stages-1], point_y, point_x};

    `DPB_ASSERT_NXT(a_zero_depth_dropped, in_xfer && (depth_raw == '0), !valid_reg[0],
        "zero depth pixel entered the pipeline")
    `DPB_ASSERT_NXT(a_pixel_entered, in_xfer && (depth_raw != '0), valid_reg[0],
        "accepted pixel was lost at entry")
    `DPB_ASSERT_IMP(a_ready_only_when_full, !s_tready, (&valid_reg) && !m_tready,
        "input stalled while the pipeline had room")
    `DPB_ASSERT_NXT(a_stalled_stage_holds, valid_reg[3] && !adv[3], valid_reg[3],
        "stalled stage dropped its item")

endmodule

// ===== sim/depth_pixel_backprojection_tb.sv =====
// self-checking testbench for depth_pixel_backprojection, streams rgb-d pixels under
// several camera register settings and checks every point against its own predictor
// depends on dpb_pkg and the depth_pixel_backprojection rtl
`timescale 1ns / 1ps

module depth_pixel_backprojection_tb;

    localparam int ClkHalf      = 5;
    localparam int ResetCycles  = 7;
    localparam int DrainCycles  = 12;
    localparam int NumRegs      = 5;
    localparam int RandPerPhase = 125;
    localparam int HoldAfter    = 150;
    localparam int HoldCycles   = 300;
    localparam int MaxReports   = 10;

    // one 3-D point as it leaves the block
    typedef struct packed {
        logic [dpb_pkg::CoordW-1:0] x;
        logic [dpb_pkg::CoordW-1:0] y;
        logic [dpb_pkg::ZW-1:0]     z;
        logic [dpb_pkg::ColorW-1:0] blue;
        logic [dpb_pkg::ColorW-1:0] green;
        logic [dpb_pkg::ColorW-1:0] red;
    } point_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [dpb_pkg::InDataW-1:0]  s_tdata = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [dpb_pkg::OutDataW-1:0] m_tdata;
    logic                         cfg_wr_en = 1'b0;
    logic [dpb_pkg::CfgIdxW-1:0]  cfg_index = '0;
    logic [dpb_pkg::CfgDataW-1:0] cfg_wdata = '0;

    // camera settings as the block should hold them
    logic [dpb_pkg::CenterW-1:0] cam_cx = dpb_pkg::CenterXRst;
    logic [dpb_pkg::CenterW-1:0] cam_cy = dpb_pkg::CenterYRst;
    logic [dpb_pkg::InvW-1:0]    cam_inv_fx = dpb_pkg::InvFocalXRst;
    logic [dpb_pkg::InvW-1:0]    cam_inv_fy = dpb_pkg::InvFocalYRst;
    logic [dpb_pkg::InvW-1:0]    cam_inv_scale = dpb_pkg::InvDepthScaleRst;

    logic [dpb_pkg::InDataW-1:0] pixel_backlog[$];
    point_t                      pending_points[$];

    int pixels_sent = 0;
    int zero_depth_pixels = 0;
    int points_checked = 0;
    int mismatches = 0;
    int phases_run = 0;

    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int mode_left = 0;
    int rx_mode = 0;

    depth_pixel_backprojection dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #ClkHalf clk = ~clk;

    // offset from the optical center times depth times reciprocal focal, toward zero
    function automatic logic [dpb_pkg::CoordW-1:0] project_axis(
        logic [dpb_pkg::PixelW-1:0] coord, logic [dpb_pkg::CenterW-1:0] center,
        logic [dpb_pkg::ZW-1:0] z, logic [dpb_pkg::InvW-1:0] inv_focal);
        logic [dpb_pkg::CenterW-1:0] pos;
        logic [dpb_pkg::CenterW-1:0] mag;
        logic                        neg;
        logic [79:0]                 full;
        logic [51:0]                 scaled;
        pos = dpb_pkg::CenterW'({coord, 4'b0000});
        neg = pos < center;
        mag = neg ? center - pos : pos - center;
        full = 80'(mag) * 80'(z) * 80'(inv_focal);
        scaled = 52'(full >> dpb_pkg::ProdShift);
        if (neg)
            scaled = ~scaled + 52'd1;
        return scaled[dpb_pkg::CoordW-1:0];
    endfunction

    // expected point for a pixel with nonzero depth
    function automatic point_t backproject(logic [dpb_pkg::InDataW-1:0] px);
        logic [dpb_pkg::PixelW-1:0] row;
        logic [dpb_pkg::PixelW-1:0] col;
        logic [dpb_pkg::DepthW-1:0] depth;
        point_t                     pt;
        row = px[11:0] & dpb_pkg::CoordMask;
        col = px[23:12] & dpb_pkg::CoordMask;
        depth = px[39:24];
        pt.z = dpb_pkg::ZW'((40'(depth) * 40'(cam_inv_scale)) >> dpb_pkg::ZShift);
        pt.x = project_axis(col, cam_cx, pt.z, cam_inv_fx);
        pt.y = project_axis(row, cam_cy, pt.z, cam_inv_fy);
        pt.blue = px[47:40];
        pt.green = px[55:48];
        pt.red = px[63:56];
        return pt;
    endfunction

    function automatic logic [dpb_pkg::InDataW-1:0] pack_pixel(int row, int col, int depth,
        int blue, int green, int red);
        return {dpb_pkg::ColorW'(red), dpb_pkg::ColorW'(green), dpb_pkg::ColorW'(blue),
                dpb_pkg::DepthW'(depth), dpb_pkg::PixelW'(col), dpb_pkg::PixelW'(row)};
    endfunction

    task automatic queue_pixel(int row, int col, int depth, int blue, int green, int red);
        pixel_backlog = {pixel_backlog, pack_pixel(row, col, depth, blue, green, red)};
    endtask

    // random pixels, some close to the optical center where the offset changes sign
    task automatic queue_random_pixels(int count);
        int row;
        int col;
        int depth;
        int pick;
        for (int i = 0; i < count; i++)
        begin
            row = $urandom_range(0, 4095);
            col = $urandom_range(0, 4095);
            if ($urandom_range(0, 7) == 0)
            begin
                col = ((cam_cx >> dpb_pkg::FracW) + $urandom_range(0, 1)) % 4096;
                row = ((cam_cy >> dpb_pkg::FracW) + $urandom_range(0, 1)) % 4096;
            end
            pick = $urandom_range(0, 9);
            case (pick)
                0: depth = 0;
                1: depth = 65535;
                2: depth = $urandom_range(1, 255);
                default: depth = $urandom_range(1, 65535);
            endcase
            queue_pixel(row, col, depth, $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255));
        end
    endtask

    // the four image corners at full depth
    task automatic queue_corners();
        queue_pixel(0, 0, 65535, 0, 255, 0);
        queue_pixel(0, 4095, 65535, 255, 0, 255);
        queue_pixel(4095, 0, 65535, 0, 0, 255);
        queue_pixel(4095, 4095, 65535, 255, 255, 0);
    endtask

    // one register write, mirrored into the expected settings
    task automatic write_reg(logic [dpb_pkg::CfgIdxW-1:0] idx,
        logic [dpb_pkg::CfgDataW-1:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            dpb_pkg::RegCenterX:       cam_cx = data[dpb_pkg::CenterW-1:0];
            dpb_pkg::RegCenterY:       cam_cy = data[dpb_pkg::CenterW-1:0];
            dpb_pkg::RegInvFocalX:     cam_inv_fx = data;
            dpb_pkg::RegInvFocalY:     cam_inv_fy = data;
            dpb_pkg::RegInvDepthScale: cam_inv_scale = data;
            default: ;
        endcase
    endtask

    task automatic write_camera(int cx, int cy, int inv_fx, int inv_fy, int inv_scale);
        // junk above the 16-bit center fields must be dropped
        write_reg(dpb_pkg::RegCenterX,
                  {dpb_pkg::ColorW'($urandom_range(0, 255)), dpb_pkg::CenterW'(cx)});
        write_reg(dpb_pkg::RegCenterY,
                  {dpb_pkg::ColorW'($urandom_range(0, 255)), dpb_pkg::CenterW'(cy)});
        write_reg(dpb_pkg::RegInvFocalX, dpb_pkg::InvW'(inv_fx));
        write_reg(dpb_pkg::RegInvFocalY, dpb_pkg::InvW'(inv_fy));
        write_reg(dpb_pkg::RegInvDepthScale, dpb_pkg::InvW'(inv_scale));
    endtask

    // wait until every queued pixel went in and every point came out
    task automatic drain();
        while (pixel_backlog.size() != 0 || s_tvalid || pending_points.size() != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
        phases_run++;
    endtask

    // pixel sender: bursts of random length with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end
        else if (!(s_tvalid && !s_tready))
        begin
            if (gap_left != 0)
            begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pixel_backlog.size() != 0)
            begin
                s_tdata <= pixel_backlog.pop_front();
                s_tvalid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // expected points, worked out as each pixel transfer is taken
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            pixels_sent++;
            if (s_tdata[39:24] == '0)
                zero_depth_pixels++;
            else
                pending_points = {pending_points, backproject(s_tdata)};
        end
    end

    // long output hold-off once, so the pipeline backs up into the input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && points_checked >= HoldAfter)
        begin
            hold_left <= HoldCycles;
            hold_done <= 1'b1;
        end
    end

    // point receiver: switches among always ready, mostly ready and mostly stalled
    always @(posedge clk or negedge rst_n)
    begin : rx_ready
        logic rdy;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            mode_left <= 0;
            rx_mode <= 0;
        end
        else
        begin
            case (rx_mode)
                0: rdy = 1'b1;
                1: rdy = $urandom_range(0, 3) != 0;
                default: rdy = $urandom_range(0, 3) == 0;
            endcase
            if (mode_left == 0)
            begin
                rx_mode <= $urandom_range(0, 2);
                mode_left <= $urandom_range(32, 200);
            end
            else
                mode_left <= mode_left - 1;
            m_tready <= rdy && (hold_left == 0);
        end
    end

    // point checker
    always @(posedge clk)
    begin : point_check
        point_t got;
        point_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.x = m_tdata[44:0];
            got.y = m_tdata[89:45];
            got.z = m_tdata[121:90];
            got.blue = m_tdata[129:122];
            got.green = m_tdata[137:130];
            got.red = m_tdata[145:138];
            if (pending_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MaxReports)
                    $display("%0t: unexpected point transfer x=%h y=%h z=%h",
                             $realtime, got.x, got.y, got.z);
            end
            else
            begin
                want = pending_points.pop_front();
                points_checked++;
                if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                    got.blue !== want.blue || got.green !== want.green ||
                    got.red !== want.red)
                begin
                    mismatches++;
                    if (mismatches <= MaxReports)
                    begin
                        $display("%0t: point %0d mismatch exp x=%h y=%h z=%h bgr=%h%h%h",
                                 $realtime, points_checked, want.x, want.y, want.z,
                                 want.blue, want.green, want.red);
                        $display("    got x=%h y=%h z=%h bgr=%h%h%h",
                                 got.x, got.y, got.z, got.blue, got.green, got.red);
                    end
                end
            end
        end
    end

    // stimulus and camera settings, phase by phase
    initial
    begin
        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: center at column 320, row 240
        queue_pixel(0, 0, 1, 0, 0, 0);
        queue_pixel(4095, 4095, 65535, 255, 255, 255);
        queue_pixel(100, 200, 0, 12, 34, 56);
        queue_pixel(240, 320, 1000, 1, 2, 3);
        queue_pixel(239, 319, 1000, 4, 5, 6);
        queue_pixel(241, 321, 1000, 7, 8, 9);
        queue_pixel(0, 4095, 65535, 128, 64, 32);
        queue_pixel(4095, 0, 65535, 32, 64, 128);
        queue_pixel(4095, 4095, 0, 255, 0, 255);
        queue_pixel(4095, 4095, 1, 0, 255, 0);
        queue_pixel(12'hAAA, 12'h555, 16'hAAAA, 8'hAA, 8'h55, 8'hAA);
        queue_pixel(12'h555, 12'hAAA, 16'h5555, 8'h55, 8'hAA, 8'h55);
        queue_pixel(240, 320, 16'h8000, 255, 255, 255);
        queue_random_pixels(RandPerPhase);
        drain();

        // centers at zero, reciprocals at full scale
        write_camera(0, 0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        queue_corners();
        queue_random_pixels(RandPerPhase);
        drain();

        // centers at the top, smallest reciprocals
        write_camera(65535, 65535, 1, 1, 1);
        queue_corners();
        queue_random_pixels(RandPerPhase);
        drain();

        // zero focal reciprocals flatten x and y; writes past the last register do nothing
        write_camera($urandom_range(0, 65535), $urandom_range(0, 65535), 0, 0,
                     $urandom_range(1, 24'hFFFFFF));
        for (int i = NumRegs; i < (1 << dpb_pkg::CfgIdxW); i++)
            write_reg(dpb_pkg::CfgIdxW'(i), dpb_pkg::CfgDataW'($urandom));
        queue_corners();
        queue_random_pixels(RandPerPhase);
        drain();

        // zero depth reciprocal flattens every point
        write_camera(5120, 3840, 32388, 32326, 0);
        queue_corners();
        queue_random_pixels(RandPerPhase);
        drain();

        // random settings over the whole register range
        for (int p = 0; p < 2; p++)
        begin
            write_camera($urandom_range(0, 65535), $urandom_range(0, 65535),
                         $urandom_range(1, 24'hFFFFFF), $urandom_range(1, 24'hFFFFFF),
                         $urandom_range(1, 24'hFFFFFF));
            queue_corners();
            queue_random_pixels(RandPerPhase);
            drain();
        end

        if (pending_points.size() != 0)
            mismatches += pending_points.size();
        $display("covered %0d pixels (%0d with zero depth) and %0d points over %0d settings",
                 pixels_sent, zero_depth_pixels, points_checked, phases_run);
        $display("settings spanned register extremes, zero reciprocals and a long hold-off");
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("timeout with %0d points still expected", pending_points.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
